// ===== hdl/clc_pkg.sv =====
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types and constants for the card number Luhn classifier.
// ----------------------------------------------------------------------------
package clc_pkg;

    // field widths
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned CLASS_W = 3;

    // digit and count limits
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    // accepted lengths
    localparam logic [COUNT_W-1:0] LEN_SHORT = 5'd13;
    localparam logic [COUNT_W-1:0] LEN_MID   = 5'd15;
    localparam logic [COUNT_W-1:0] LEN_LONG  = 5'd16;

    // class codes
    typedef enum logic [CLASS_W-1:0] {
        CLS_INVALID   = 3'd0,
        CLS_PREFIX_4  = 3'd1,
        CLS_PREFIX_5X = 3'd2,
        CLS_PREFIX_3X = 3'd3,
        CLS_UNKNOWN   = 3'd4
    } t_class;

    // one digit request
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } t_digit_req;

    // one classification result
    typedef struct packed {
        t_class             class_code;
        logic [COUNT_W-1:0] digit_total;
    } t_result;

endpackage

// ===== hdl/clc_in_stage.sv =====
// ----------------------------------------------------------------------------
// clc_in_stage
// Input register of the digit channel, held while the next stage is blocked.
// ----------------------------------------------------------------------------
module clc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  clc_pkg::t_digit_req i_req,
    input  logic                i_advance,
    output logic                o_req_valid,
    output clc_pkg::t_digit_req o_req
);
    import clc_pkg::*;

    logic       r_valid;
    logic       n_valid;
    t_digit_req r_req;
    logic       w_accept;

    // stall only while a held request cannot move on
    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    // valid bit next value
    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    assign o_req_valid = r_valid;
    assign o_req       = r_req;

endmodule

// ===== hdl/clc_accum.sv =====
// ----------------------------------------------------------------------------
// clc_accum
// Running digit count, leading digits and both Luhn sums, plus the final
// length, checksum and prefix classification on the last digit.
// ----------------------------------------------------------------------------
module clc_accum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  clc_pkg::t_digit_req i_req,
    output clc_pkg::t_result    o_result
);
    import clc_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [DIGIT_W-1:0] r_first;
    logic [DIGIT_W-1:0] r_second;
    logic [3:0]         r_sum_even;
    logic [3:0]         r_sum_odd;
    logic [COUNT_W-1:0] n_count;
    logic [DIGIT_W-1:0] n_first;
    logic [DIGIT_W-1:0] n_second;
    logic [3:0]         n_sum_even;
    logic [3:0]         n_sum_odd;

    logic [DIGIT_W-1:0] w_d;
    logic [4:0]         w_d2;
    logic [3:0]         w_dd;
    logic [4:0]         w_s_even;
    logic [4:0]         w_s_odd;
    logic [3:0]         w_sum_even;
    logic [3:0]         w_sum_odd;
    logic [COUNT_W-1:0] w_total;
    logic [3:0]         w_sum;
    logic               w_len_ok;
    t_class             w_class;

    // saturate the digit and form its doubled value
    assign w_d  = (i_req.digit > DIGIT_MAX) ? DIGIT_MAX : i_req.digit;
    assign w_d2 = {w_d, 1'b0};
    assign w_dd = (w_d2 >= 5'd10) ? 4'(w_d2 - 5'd9) : w_d2[3:0];

    // mod-10 sums, doubled term picked by index parity from the left
    always_comb begin
        if (!r_count[0]) begin
            w_s_even = {1'b0, r_sum_even} + {1'b0, w_dd};
            w_s_odd  = {1'b0, r_sum_odd} + {1'b0, w_d};
        end else begin
            w_s_even = {1'b0, r_sum_even} + {1'b0, w_d};
            w_s_odd  = {1'b0, r_sum_odd} + {1'b0, w_dd};
        end
    end
    assign w_sum_even = (w_s_even >= 5'd10) ? 4'(w_s_even - 5'd10) : w_s_even[3:0];
    assign w_sum_odd  = (w_s_odd >= 5'd10) ? 4'(w_s_odd - 5'd10) : w_s_odd[3:0];

    // count including this digit
    assign w_total = (r_count < COUNT_MAX) ? r_count + 5'd1 : r_count;

    // even length doubles even indices from the left
    assign w_sum    = w_total[0] ? w_sum_odd : w_sum_even;
    assign w_len_ok = (w_total == LEN_SHORT) || (w_total == LEN_MID) || (w_total == LEN_LONG);

    // classification
    always_comb begin
        if (!w_len_ok || (w_sum != 4'd0)) begin
            w_class = CLS_INVALID;
        end else if (((w_total == LEN_SHORT) || (w_total == LEN_LONG)) && (r_first == 4'd4)) begin
            w_class = CLS_PREFIX_4;
        end else if ((w_total == LEN_LONG) && (r_first == 4'd5) && (r_second >= 4'd1)
                     && (r_second <= 4'd5)) begin
            w_class = CLS_PREFIX_5X;
        end else if ((w_total == LEN_MID) && (r_first == 4'd3)
                     && ((r_second == 4'd4) || (r_second == 4'd7))) begin
            w_class = CLS_PREFIX_3X;
        end else begin
            w_class = CLS_UNKNOWN;
        end
    end

    assign o_result.class_code  = w_class;
    assign o_result.digit_total = w_total;

    // state next values, cleared after the last digit
    always_comb begin
        n_count    = r_count;
        n_first    = r_first;
        n_second   = r_second;
        n_sum_even = r_sum_even;
        n_sum_odd  = r_sum_odd;
        if (i_advance) begin
            if (i_req.last_digit) begin
                n_count    = '0;
                n_first    = '0;
                n_second   = '0;
                n_sum_even = '0;
                n_sum_odd  = '0;
            end else begin
                n_count    = w_total;
                n_sum_even = w_sum_even;
                n_sum_odd  = w_sum_odd;
                if (r_count == 5'd0) begin
                    n_first = w_d;
                end else if (r_count == 5'd1) begin
                    n_second = w_d;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_first    <= '0;
            r_second   <= '0;
            r_sum_even <= '0;
            r_sum_odd  <= '0;
        end else begin
            r_count    <= n_count;
            r_first    <= n_first;
            r_second   <= n_second;
            r_sum_even <= n_sum_even;
            r_sum_odd  <= n_sum_odd;
        end
    end

endmodule

// ===== hdl/clc_out_stage.sv =====
// ----------------------------------------------------------------------------
// clc_out_stage
// Result register of the output channel and the advance decision for the
// request held in the input stage.
// ----------------------------------------------------------------------------
module clc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_last,
    input  clc_pkg::t_result i_result,
    output logic             o_advance,
    output logic             o_valid,
    input  logic             i_stall,
    output clc_pkg::t_result o_result
);
    import clc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    logic    w_free;
    logic    w_load;

    // slot is free when empty or being taken this cycle
    assign w_free    = !r_valid || !i_stall;
    assign o_advance = i_req_valid && (!i_req_last || w_free);
    assign w_load    = o_advance && i_req_last;

    // valid bit next value
    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hdl/card_number_luhn_classifier.sv =====
// ----------------------------------------------------------------------------
// card_number_luhn_classifier
// Luhn mod-10 check and prefix classification of a card number, one digit
// a request, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_digit and i_last_digit. A request
//   is taken at a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_class_code and o_digit_total, one
//   result for each request marked as the last digit; other requests give
//   none.
//   Throughput: one digit per cycle while o_stall is low, set by the single
//   pass through the accumulator between the input register and the result
//   register. A last digit is held in the input register, then its result is
//   loaded into the result register once that is free and is shown from there.
//   Stall: a stalled result holds in the result register; further digits
//   are still taken, and o_stall rises only when a last digit waits behind a
//   result that is not yet taken.
//   Reset: i_rst_n low at a clock edge empties both registers and clears the
//   count, leading digits and sums; the block is ready in the next cycle.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [clc_pkg::DIGIT_W-1:0]  i_digit,
    input  logic                         i_last_digit,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [clc_pkg::CLASS_W-1:0]  o_class_code,
    output logic [clc_pkg::COUNT_W-1:0]  o_digit_total
);
    import clc_pkg::*;

    t_digit_req w_in_req;
    t_digit_req w_held_req;
    logic       w_held_valid;
    logic       w_advance;
    t_result    w_next_result;
    t_result    w_out_result;

    assign w_in_req.digit      = i_digit;
    assign w_in_req.last_digit = i_last_digit;

    // input register
    clc_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (w_in_req),
        .i_advance   (w_advance),
        .o_req_valid (w_held_valid),
        .o_req       (w_held_req)
    );

    // count, sums and classification
    clc_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_req     (w_held_req),
        .o_result  (w_next_result)
    );

    // result register
    clc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_held_valid),
        .i_req_last  (w_held_req.last_digit),
        .i_result    (w_next_result),
        .o_advance   (w_advance),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (w_out_result)
    );

    assign o_class_code  = w_out_result.class_code;
    assign o_digit_total = w_out_result.digit_total;

`ifndef SYNTHESIS
    // input is blocked only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // a non-invalid class only comes with an accepted length
    a_len_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_class_code != CLS_INVALID)) |->
        ((o_digit_total == LEN_SHORT) || (o_digit_total == LEN_MID)
         || (o_digit_total == LEN_LONG)))
        else $error("valid class with a bad length");

    // prefix 3x type is only a 15 digit number
    a_class_3x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_class_code == CLS_PREFIX_3X)) |-> (o_digit_total == LEN_MID))
        else $error("prefix 3x class with wrong length");

    // prefix 5x type is only a 16 digit number
    a_class_5x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_class_code == CLS_PREFIX_5X)) |-> (o_digit_total == LEN_LONG))
        else $error("prefix 5x class with wrong length");
`endif

endmodule

// ===== tb/luhn_result_checker.sv =====
// ----------------------------------------------------------------------------
// luhn_result_checker
// Watches both channels of the card number classifier. It predicts the class
// code and digit total of each number from the digit requests it sees, and
// compares every result taken from the block against the oldest prediction.
// ----------------------------------------------------------------------------
module luhn_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic [clc_pkg::DIGIT_W-1:0] i_digit,
    input  logic                        i_last_digit,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [clc_pkg::CLASS_W-1:0] o_class_code,
    input  logic [clc_pkg::COUNT_W-1:0] o_digit_total,
    output int                          o_mismatches,
    output int                          o_awaiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import clc_pkg::*;

    // predicted state of the number in progress
    logic [COUNT_W-1:0] digits_seen;
    logic [DIGIT_W-1:0] lead_digit;
    logic [DIGIT_W-1:0] next_digit;
    logic [DIGIT_W-1:0] sum_even_doubled;
    logic [DIGIT_W-1:0] sum_odd_doubled;

    t_result expected_classes[$];
    int      mismatch_count = 0;
    int      awaiting_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_awaiting   = awaiting_count;

    // both operands at most nine, so one wrap is enough
    function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] acc,
                                                      input logic [DIGIT_W-1:0] val);
        int s;
        s = int'(acc) + int'(val);
        if (s >= 10) s = s - 10;
        return DIGIT_W'(s);
    endfunction

    function automatic logic [DIGIT_W-1:0] luhn_doubled(input logic [DIGIT_W-1:0] val);
        int t;
        t = 2 * int'(val);
        if (t >= 10) t = t - 9;
        return DIGIT_W'(t);
    endfunction

    always @(posedge i_clk) begin
        logic [DIGIT_W-1:0] d;
        logic [DIGIT_W-1:0] dd;
        logic [DIGIT_W-1:0] chosen_sum;
        logic [COUNT_W-1:0] total;
        t_result            pred;
        t_result            oldest;

        if (!i_rst_n) begin
            digits_seen      = '0;
            lead_digit       = '0;
            next_digit       = '0;
            sum_even_doubled = '0;
            sum_odd_doubled  = '0;
            expected_classes.delete();
        end else begin
            // result side first: a result taken now belongs to an older number
            if (o_valid && !i_stall) begin
                if (expected_classes.size() == 0) begin
                    $error("unexpected result: class_code %0d digit_total %0d",
                           o_class_code, o_digit_total);
                    mismatch_count++;
                end else begin
                    oldest = expected_classes.pop_front();
                    if (o_class_code !== oldest.class_code) begin
                        $error("class_code expected %0d actual %0d",
                               oldest.class_code, o_class_code);
                        mismatch_count++;
                    end
                    if (o_digit_total !== oldest.digit_total) begin
                        $error("digit_total expected %0d actual %0d",
                               oldest.digit_total, o_digit_total);
                        mismatch_count++;
                    end
                end
            end

            // digit request side
            if (i_valid && !o_stall) begin
                d  = (i_digit > DIGIT_MAX) ? DIGIT_MAX : i_digit;
                dd = luhn_doubled(d);

                if (digits_seen == 0) lead_digit = d;
                else if (digits_seen == 1) next_digit = d;

                // track both doubling parities since the length is unknown
                if (!digits_seen[0]) begin
                    sum_even_doubled = add_mod10(sum_even_doubled, dd);
                    sum_odd_doubled  = add_mod10(sum_odd_doubled, d);
                end else begin
                    sum_even_doubled = add_mod10(sum_even_doubled, d);
                    sum_odd_doubled  = add_mod10(sum_odd_doubled, dd);
                end

                if (digits_seen < COUNT_MAX) digits_seen = digits_seen + 1'b1;

                if (i_last_digit) begin
                    total = digits_seen;
                    // even length puts the doubled digits at even index
                    chosen_sum = total[0] ? sum_odd_doubled : sum_even_doubled;

                    if (total != LEN_SHORT && total != LEN_MID && total != LEN_LONG)
                        pred.class_code = CLS_INVALID;
                    else if (chosen_sum != 0)
                        pred.class_code = CLS_INVALID;
                    else if ((total == LEN_SHORT || total == LEN_LONG) && lead_digit == 4)
                        pred.class_code = CLS_PREFIX_4;
                    else if (total == LEN_LONG && lead_digit == 5 &&
                             next_digit >= 1 && next_digit <= 5)
                        pred.class_code = CLS_PREFIX_5X;
                    else if (total == LEN_MID && lead_digit == 3 &&
                             (next_digit == 4 || next_digit == 7))
                        pred.class_code = CLS_PREFIX_3X;
                    else
                        pred.class_code = CLS_UNKNOWN;
                    pred.digit_total = total;
                    expected_classes.push_back(pred);

                    // clear for the next number
                    digits_seen      = '0;
                    lead_digit       = '0;
                    next_digit       = '0;
                    sum_even_doubled = '0;
                    sum_odd_doubled  = '0;
                end
            end
        end
        awaiting_count = expected_classes.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the card number classifier: a few directed numbers, then
// random card numbers, mostly well formed with valid or broken check digits,
// plus random lengths, digits above nine and over-long numbers. Both sides
// idle in random bursts; the checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import clc_pkg::*;

    localparam int IDLE_LIMIT  = 400;
    localparam int ITEM_TARGET = 700;
    localparam int QUIET_FROM  = 600;

    typedef logic [DIGIT_W-1:0] t_digit_q[$];

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [DIGIT_W-1:0] i_digit      = '0;
    logic               i_last_digit = 1'b0;
    logic               i_stall      = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [CLASS_W-1:0] o_class_code;
    logic [COUNT_W-1:0] o_digit_total;

    int mismatches;
    int awaiting;
    int digits_sent  = 0;
    int sender_busy  = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;
    bit quiet        = 1'b0;

    always #1 i_clk = ~i_clk;

    card_number_luhn_classifier DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_digit      (i_digit),
        .i_last_digit (i_last_digit),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_class_code (o_class_code),
        .o_digit_total(o_digit_total)
    );

    luhn_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_digit      (i_digit),
        .i_last_digit (i_last_digit),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_class_code (o_class_code),
        .o_digit_total(o_digit_total),
        .o_mismatches (mismatches),
        .o_awaiting   (awaiting)
    );

    // receiver stall in random bursts
    always @(posedge i_clk) begin
        if (quiet) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[card_number_luhn_classifier] ERROR");
            $finish;
        end
    end

    // one digit request, with an optional idle burst ahead of it
    task automatic send_digit(input logic [DIGIT_W-1:0] d, input logic last);
        if (!quiet && sender_busy != 0 && $urandom_range(0, 7) < sender_busy) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_digit      <= d;
        i_last_digit <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        digits_sent++;
        if (digits_sent >= QUIET_FROM) quiet = 1'b1;
    endtask

    task automatic send_card(input t_digit_q card);
        sender_busy = $urandom_range(0, 3);
        foreach (card[i]) send_digit(card[i], i == card.size() - 1);
    endtask

    // hold off until every predicted result has been taken
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (awaiting != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // card number with a chosen prefix and a good or broken check digit
    task automatic build_card(input int len, input int lead, input bit good,
                              output t_digit_q card);
        int sum;
        int v;
        int check;
        card = {};
        case (lead)
            0: card.push_back(4'd4);
            1: begin
                card.push_back(4'd5);
                card.push_back(DIGIT_W'($urandom_range(0, 6)));
            end
            2: begin
                card.push_back(4'd3);
                case ($urandom_range(0, 2))
                    0: card.push_back(4'd4);
                    1: card.push_back(4'd7);
                    default: card.push_back(DIGIT_W'($urandom_range(0, 9)));
                endcase
            end
            default: card.push_back(DIGIT_W'($urandom_range(0, 9)));
        endcase
        while (card.size() > len - 1 && card.size() > 0) void'(card.pop_back());
        while (card.size() < len - 1) card.push_back(DIGIT_W'($urandom_range(0, 9)));

        // check digit from the right: the digit left of it is doubled
        sum = 0;
        foreach (card[i]) begin
            v = int'(card[i]);
            if ((len - 1 - i) % 2 == 1) begin
                v = 2 * v;
                if (v > 9) v = v - 9;
            end
            sum += v;
        end
        check = (10 - sum % 10) % 10;
        if (!good) check = (check + $urandom_range(1, 9)) % 10;
        card.push_back(DIGIT_W'(check));

        // a nine may travel as any out-of-range code
        foreach (card[i])
            if (card[i] == 9 && $urandom_range(0, 3) == 0)
                card[i] = DIGIT_W'($urandom_range(10, 15));
    endtask

    initial begin
        t_digit_q card;
        int       pick;
        int       lead;
        int       len;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single zero, codes above nine, a valid short prefix-4 number and a seven-digit number
        card = {4'd0};
        send_card(card);
        card = {4'd15, 4'd10};
        send_card(card);
        build_card(13, 0, 1'b1, card);
        send_card(card);
        card = {4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3};
        send_card(card);
        drain_results();

        // random card numbers
        while (digits_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                lead = $urandom_range(0, 3);
                case (lead)
                    0: len = ($urandom_range(0, 1) == 0) ? 13 : 16;
                    1: len = 16;
                    2: len = 15;
                    default: len = $urandom_range(13, 16);
                endcase
                if ($urandom_range(0, 7) == 0) len = $urandom_range(12, 17);
                build_card(len, lead, $urandom_range(0, 4) != 0, card);
            end else if (pick < 97) begin
                // noise: random length and raw codes
                len  = $urandom_range(1, 20);
                card = {};
                repeat (len) card.push_back(DIGIT_W'($urandom_range(0, 15)));
            end else begin
                // up to and past the saturation point of the count
                build_card($urandom_range(30, 40), $urandom_range(0, 3), 1'b1, card);
            end
            send_card(card);
            if ($urandom_range(0, 24) == 0) drain_results();
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[card_number_luhn_classifier] OK");
        end else begin
            $display("[card_number_luhn_classifier] ERROR");
        end
        $finish;
    end

endmodule
